### src/afbu_pkg.sv
package afbu_pkg;

   localparam int VALUE_W = 16;
   localparam int KIND_W = 3;
   localparam int MAG_W = 17;
   localparam int FRAC_POS_W = 16;

   localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SIGMOID = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TANH    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RELU    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LEAKY   = 3'd4;

   localparam logic ACTION_FORWARD  = 1'b0;
   localparam logic ACTION_BACKWARD = 1'b1;

   localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
   localparam logic [63:0] Q30_MASK = (64'd1 << 30) - 64'd1;

   localparam logic signed [47:0] SAT_MAX = 48'sd32767;
   localparam logic signed [47:0] SAT_MIN = -48'sd32768;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [3:0] {
      OP_PASS_VALUE,
      OP_PASS_GRAD,
      OP_SIG_FWD,
      OP_SIG_BWD,
      OP_TANH_FWD,
      OP_TANH_BWD,
      OP_RELU_FWD,
      OP_RELU_BWD,
      OP_LEAKY_FWD,
      OP_LEAKY_BWD
   } op_type;

   function automatic value_type sat_value(input logic signed [47:0] v);
      value_type r;
      if (v > SAT_MAX) begin
         r = 16'sh7FFF;
      end else if (v < SAT_MIN) begin
         r = 16'sh8000;
      end else begin
         r = value_type'(v[VALUE_W-1:0]);
      end
      return r;
   endfunction

   // Elaboration-time helpers for the tanh curve table.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] exp_neg_unit(input logic [63:0] f);
      logic [63:0] s;
      logic [63:0] t;
      s = Q30_ONE;
      t = Q30_ONE;
      for (int k = 1; k <= 24; k++) begin
         t = udiv64(t * f, 64'(k) << 30);
         if (k[0]) begin
            s = (t > s) ? 64'd0 : s - t;
         end else begin
            s = s + t;
         end
      end
      return s;
   endfunction

   function automatic logic [63:0] exp_neg(input logic [63:0] y);
      logic [63:0] n;
      logic [63:0] s;
      logic [63:0] e1;
      n = y >> 30;
      s = exp_neg_unit(y & Q30_MASK);
      e1 = exp_neg_unit(Q30_ONE);
      while (n != 64'd0 && s != 64'd0) begin
         s = (s * e1 + (64'd1 << 29)) >> 30;
         n = n - 64'd1;
      end
      return s;
   endfunction

   function automatic logic [63:0] curve_entry(input int frac, input int entries, input int k);
      logic [63:0] y;
      logic [63:0] e;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] t;
      y = udiv64((64'(k) << (46 - frac)) + 64'(entries >> 1), 64'(entries));
      e = exp_neg(y);
      num = (Q30_ONE - e) << 30;
      den = Q30_ONE + e;
      t = udiv64(num + (den >> 1), den);
      return (t + (64'd1 << (29 - frac))) >> (30 - frac);
   endfunction

endpackage

### src/activation_forward_backward_unit_top.sv
// An accepted start reaches the rsp_valid strobe through the valid registers v1_ff, v2_ff, v3_ff and v4_ff.
// Throughput: one transaction per cycle; busy never asserts.
// Four register stages: index/product, table read, interpolate/gradient, result.
// Reset clears the stage valid bits and sets the activation kind to none.
// The receiver cannot stall: each result is strobed for exactly one cycle.
module activation_forward_backward_unit_top import afbu_pkg::*; #(
   parameter int FRAC_BITS = 12,
   parameter int CURVE_TABLE_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_action,
   input  value_type         req_value,
   input  value_type         req_upstream_grad,
   output logic              rsp_valid,
   output value_type         rsp_result,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [KIND_W-1:0] csr_activation_kind
);

   localparam int CURVE_W = FRAC_BITS + 1;
   localparam int IDX_W = $clog2(CURVE_TABLE_ENTRIES + 1);
   localparam int POS_W = MAG_W + IDX_W;
   localparam int CPROD_W = CURVE_W + FRAC_POS_W;
   localparam int ONE = 1 << FRAC_BITS;
   localparam int HALF = 1 << (FRAC_BITS - 1);
   localparam int SLOPE = ((1 << FRAC_BITS) + 50) / 100;
   localparam logic signed [17:0] ONE_W = 18'(ONE);
   localparam logic signed [17:0] SLOPE_W = 18'(SLOPE);
   localparam value_type ONE_VALUE = 16'(ONE);
   localparam logic [IDX_W:0] LAST_IDX = (IDX_W + 1)'(CURVE_TABLE_ENTRIES);

   logic [KIND_W-1:0] kind_ff;
   logic accept;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_NONE;
      end else if (csr_valid && csr_ready) begin
         kind_ff <= csr_activation_kind;
      end
   end

   // Stage 0: decode, magnitude, table position and first product
   op_type               op_in;
   logic                 neg_in;
   logic [MAG_W-1:0]     mag;
   logic [MAG_W-1:0]     m_in;
   logic [POS_W-1:0]     pos_in;
   value_type            ma;
   logic signed [17:0]   mb;
   logic signed [33:0]   p1_in;

   always_comb begin
      unique case (kind_ff)
         KIND_NONE:    op_in = (req_action == ACTION_BACKWARD) ? OP_PASS_GRAD : OP_PASS_VALUE;
         KIND_SIGMOID: op_in = (req_action == ACTION_BACKWARD) ? OP_SIG_BWD : OP_SIG_FWD;
         KIND_TANH:    op_in = (req_action == ACTION_BACKWARD) ? OP_TANH_BWD : OP_TANH_FWD;
         KIND_RELU:    op_in = (req_action == ACTION_BACKWARD) ? OP_RELU_BWD : OP_RELU_FWD;
         KIND_LEAKY:   op_in = (req_action == ACTION_BACKWARD) ? OP_LEAKY_BWD : OP_LEAKY_FWD;
         default:      op_in = (req_action == ACTION_BACKWARD) ? OP_PASS_GRAD : OP_PASS_VALUE;
      endcase
      neg_in = req_value[VALUE_W-1];
      mag = neg_in ? MAG_W'(-(MAG_W'(req_value))) : MAG_W'(req_value);
      m_in = (op_in == OP_TANH_FWD) ? {mag[MAG_W-2:0], 1'b0} : mag;
      pos_in = POS_W'(m_in) * POS_W'(CURVE_TABLE_ENTRIES);
      unique case (op_in)
         OP_SIG_BWD: begin
            ma = req_value;
            mb = ONE_W - 18'(req_value);
         end
         OP_TANH_BWD: begin
            ma = req_value;
            mb = 18'(req_value);
         end
         OP_LEAKY_FWD: begin
            ma = req_value;
            mb = SLOPE_W;
         end
         OP_LEAKY_BWD: begin
            ma = req_upstream_grad;
            mb = SLOPE_W;
         end
         default: begin
            ma = req_value;
            mb = '0;
         end
      endcase
      p1_in = 34'(ma) * 34'(mb);
   end

   logic                 v1_ff;
   op_type               op1_ff;
   logic                 neg1_ff;
   value_type            x1_ff;
   value_type            g1_ff;
   logic [POS_W-1:0]     pos1_ff;
   logic signed [33:0]   p1_ff;

   always_ff @(posedge clock) begin
      op1_ff  <= op_in;
      neg1_ff <= neg_in;
      x1_ff   <= req_value;
      g1_ff   <= req_upstream_grad;
      pos1_ff <= pos_in;
      p1_ff   <= p1_in;
   end

   // Stage 1: table addresses, fraction, derivative or leak term
   logic [IDX_W:0]            idx_full;
   logic                      over;
   logic [IDX_W-1:0]          addr_a;
   logic [IDX_W-1:0]          addr_b;
   logic [FRAC_POS_W-1:0]     fr_in;
   logic signed [33:0]        rs1;
   value_type                 d_in;

   always_comb begin
      idx_full = pos1_ff[POS_W-1:FRAC_POS_W];
      over = idx_full >= LAST_IDX;
      addr_a = over ? LAST_IDX[IDX_W-1:0] : idx_full[IDX_W-1:0];
      addr_b = over ? LAST_IDX[IDX_W-1:0] : addr_a + 1'b1;
      fr_in = over ? '0 : pos1_ff[FRAC_POS_W-1:0];
      rs1 = (p1_ff + 34'(HALF)) >>> FRAC_BITS;
      unique case (op1_ff)
         OP_SIG_BWD:   d_in = sat_value(48'(rs1));
         OP_TANH_BWD:  d_in = sat_value(48'(ONE) - 48'(rs1));
         OP_LEAKY_FWD,
         OP_LEAKY_BWD: d_in = sat_value(48'(rs1));
         default:      d_in = '0;
      endcase
   end

   logic [CURVE_W-1:0]    a2;
   logic [CURVE_W-1:0]    b2;

   afbu_curve_rom #(
      .FRAC_BITS (FRAC_BITS),
      .ENTRIES   (CURVE_TABLE_ENTRIES)
   ) u_curve_rom (
      .clock     (clock),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (a2),
      .rd_data_b (b2)
   );

   logic                    v2_ff;
   op_type                  op2_ff;
   logic                    neg2_ff;
   value_type               x2_ff;
   value_type               g2_ff;
   value_type               d2_ff;
   logic [FRAC_POS_W-1:0]   fr2_ff;

   always_ff @(posedge clock) begin
      op2_ff  <= op1_ff;
      neg2_ff <= neg1_ff;
      x2_ff   <= x1_ff;
      g2_ff   <= g1_ff;
      d2_ff   <= d_in;
      fr2_ff  <= fr_in;
   end

   // Stage 2: interpolation product and gradient product
   logic [CURVE_W-1:0]    diff;
   logic [CPROD_W-1:0]    cprod_in;
   logic signed [31:0]    gprod_in;

   always_comb begin
      diff = (b2 > a2) ? b2 - a2 : '0;
      cprod_in = CPROD_W'(diff) * CPROD_W'(fr2_ff);
      gprod_in = 32'(g2_ff) * 32'(d2_ff);
   end

   logic                  v3_ff;
   op_type                op3_ff;
   logic                  neg3_ff;
   value_type             x3_ff;
   value_type             g3_ff;
   value_type             d3_ff;
   logic [CURVE_W-1:0]    a3_ff;
   logic [CPROD_W-1:0]    cprod3_ff;
   logic signed [31:0]    gprod3_ff;

   always_ff @(posedge clock) begin
      op3_ff    <= op2_ff;
      neg3_ff   <= neg2_ff;
      x3_ff     <= x2_ff;
      g3_ff     <= g2_ff;
      d3_ff     <= d2_ff;
      a3_ff     <= a2;
      cprod3_ff <= cprod_in;
      gprod3_ff <= gprod_in;
   end

   // Stage 3: curve value, sign, rounding and final select
   logic [CPROD_W-1:0]    crnd;
   logic [CURVE_W:0]      y;
   logic signed [17:0]    sy;
   logic signed [17:0]    sig_sum;
   logic signed [31:0]    gq;
   logic                  pos3;
   value_type             res_in;

   always_comb begin
      crnd = cprod3_ff + CPROD_W'(32768);
      y = (CURVE_W + 1)'(a3_ff) + (CURVE_W + 1)'(crnd[CPROD_W-1:FRAC_POS_W]);
      sy = neg3_ff ? -(18'(y)) : 18'(y);
      sig_sum = ONE_W + sy + 18'sd1;
      gq = (gprod3_ff + 32'(HALF)) >>> FRAC_BITS;
      pos3 = !x3_ff[VALUE_W-1] && (x3_ff != '0);
      unique case (op3_ff)
         OP_PASS_VALUE: res_in = x3_ff;
         OP_PASS_GRAD:  res_in = g3_ff;
         OP_SIG_FWD:    res_in = value_type'(sig_sum[VALUE_W:1]);
         OP_TANH_FWD:   res_in = value_type'(sy[VALUE_W-1:0]);
         OP_SIG_BWD,
         OP_TANH_BWD:   res_in = sat_value(48'(gq));
         OP_RELU_FWD:   res_in = pos3 ? x3_ff : '0;
         OP_RELU_BWD:   res_in = pos3 ? g3_ff : '0;
         OP_LEAKY_FWD:  res_in = pos3 ? x3_ff : d3_ff;
         OP_LEAKY_BWD:  res_in = pos3 ? g3_ff : d3_ff;
         default:       res_in = x3_ff;
      endcase
   end

   logic        v4_ff;
   value_type   res4_ff;

   always_ff @(posedge clock) begin
      res4_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_result = res4_ff;

   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("transaction accepted without a result four cycles later");

   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result strobe without an accepted transaction");

   a_relu_nonneg: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && op3_ff == OP_RELU_FWD) |=> !rsp_result[VALUE_W-1])
      else $error("relu forward result is negative");

   a_sigmoid_range: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && op3_ff == OP_SIG_FWD) |=>
         (!rsp_result[VALUE_W-1] && rsp_result <= ONE_VALUE))
      else $error("sigmoid forward result out of range");

endmodule

### src/afbu_curve_rom.sv
module afbu_curve_rom import afbu_pkg::*; #(
   parameter int FRAC_BITS = 12,
   parameter int ENTRIES = 256,
   localparam int CURVE_W = FRAC_BITS + 1,
   localparam int IDX_W = $clog2(ENTRIES + 1)
) (
   input  logic               clock,
   input  logic [IDX_W-1:0]   rd_addr_a,
   input  logic [IDX_W-1:0]   rd_addr_b,
   output logic [CURVE_W-1:0] rd_data_a,
   output logic [CURVE_W-1:0] rd_data_b
);

   logic [CURVE_W-1:0] rom_entry [ENTRIES+1];
   logic [CURVE_W-1:0] data_a_ff;
   logic [CURVE_W-1:0] data_b_ff;

   for (genvar k = 0; k <= ENTRIES; k++) begin : g_entry
      localparam logic [63:0] ENTRY_VAL = curve_entry(FRAC_BITS, ENTRIES, k);
      assign rom_entry[k] = ENTRY_VAL[CURVE_W-1:0];
   end

   always_ff @(posedge clock) begin
      data_a_ff <= rom_entry[rd_addr_a];
      data_b_ff <= rom_entry[rd_addr_b];
   end

   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule

### test/activation_forward_backward_unit_top_tb.sv
module activation_forward_backward_unit_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import afbu_pkg::*;

   localparam int FRAC = 12;
   localparam int CURVE_N = 256;
   localparam longint FX_ONE = longint'(1) << FRAC;
   localparam longint LEAK_SLOPE = ((longint'(1) << FRAC) + 50) / 100;
   localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
   localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;
   localparam value_type VALUE_MIN = 16'sh8000;
   localparam value_type VALUE_MAX = 16'sh7FFF;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_SHOWN = 10;

   typedef enum logic [1:0] {ENTRY_ITEM, ENTRY_CSR, ENTRY_DRAIN} entry_type;

   typedef struct {
      entry_type         what;
      logic              action;
      value_type         value;
      value_type         grad;
      logic [KIND_W-1:0] kind;
      int                gap;
   } work_entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_action = ACTION_FORWARD;
   value_type         req_value = '0;
   value_type         req_upstream_grad = '0;
   logic              rsp_valid;
   value_type         rsp_result;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [KIND_W-1:0] csr_activation_kind = KIND_NONE;

   logic              req_taken = 1'b0;
   logic              csr_taken = 1'b0;
   logic [KIND_W-1:0] active_kind = KIND_NONE;
   int                settle_left = SETTLE_CYCLES;
   int                mismatch_count = 0;
   longint            tanh_curve [0:CURVE_N];
   work_entry_type    pending_work [$];
   value_type         awaited_results [$];

   activation_forward_backward_unit_top #(
      .FRAC_BITS(FRAC),
      .CURVE_TABLE_ENTRIES(CURVE_N)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_value(req_value),
      .req_upstream_grad(req_upstream_grad),
      .rsp_valid(rsp_valid),
      .rsp_result(rsp_result),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_activation_kind(csr_activation_kind)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // e^-f, f in Q30 within [0, 1], by a truncated series
   function automatic longint unsigned exp_decay_unit(input longint unsigned f);
      longint unsigned s;
      longint unsigned t;
      s = UNIT_Q30;
      t = UNIT_Q30;
      for (int k = 1; k <= 24; k++) begin
         t = (t * f) / (64'(k) << 30);
         if (k % 2 == 1) begin
            s = (t > s) ? 64'd0 : s - t;
         end else begin
            s = s + t;
         end
      end
      return s;
   endfunction

   function automatic longint round_q(input longint v);
      return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint clamp16(input longint v);
      if (v > 32767) begin
         return 32767;
      end
      if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   // m: magnitude with FRAC+1 fraction bits
   function automatic longint curve_lookup(input longint m);
      longint pos;
      longint idx;
      longint fr;
      longint a;
      longint b;
      longint d;
      pos = m * CURVE_N;
      idx = pos >>> 16;
      fr = pos & 64'hFFFF;
      if (idx >= CURVE_N) begin
         return tanh_curve[CURVE_N];
      end
      a = tanh_curve[idx];
      b = tanh_curve[idx + 1];
      d = (b > a) ? b - a : 0;
      return a + ((d * fr + 32768) >>> 16);
   endfunction

   function automatic value_type predict_activation(input logic [KIND_W-1:0] kind,
         input logic action, input value_type value, input value_type grad);
      longint x;
      longint g;
      longint mag;
      longint y;
      longint d;
      longint r;
      x = value;
      g = grad;
      mag = (x < 0) ? -x : x;
      case (kind)
         KIND_SIGMOID: begin
            if (action == ACTION_FORWARD) begin
               y = curve_lookup(mag);
               r = (FX_ONE + ((x < 0) ? -y : y) + 1) / 2;
            end else begin
               d = clamp16(round_q(x * (FX_ONE - x)));
               r = round_q(g * d);
            end
         end
         KIND_TANH: begin
            if (action == ACTION_FORWARD) begin
               y = curve_lookup(mag * 2);
               r = (x < 0) ? -y : y;
            end else begin
               d = clamp16(FX_ONE - round_q(x * x));
               r = round_q(g * d);
            end
         end
         KIND_RELU: begin
            if (action == ACTION_FORWARD) begin
               r = (x > 0) ? x : 0;
            end else begin
               r = (x > 0) ? g : 0;
            end
         end
         KIND_LEAKY: begin
            if (action == ACTION_FORWARD) begin
               r = (x > 0) ? x : round_q(x * LEAK_SLOPE);
            end else begin
               r = (x > 0) ? g : round_q(g * LEAK_SLOPE);
            end
         end
         default: begin
            r = (action == ACTION_BACKWARD) ? g : x;
         end
      endcase
      return value_type'(clamp16(r));
   endfunction

   function automatic value_type rand_word();
      value_type corners [7];
      corners = '{VALUE_MIN, VALUE_MAX, 16'sd0, 16'sd1, -16'sd1, 16'sd4096, -16'sd4096};
      case ($urandom_range(0, 3))
         0: return value_type'(int'($urandom_range(0, 16384)) - 8192);
         1: return corners[$urandom_range(0, 6)];
         default: return value_type'($urandom);
      endcase
   endfunction

   task automatic queue_item(input logic action, input value_type value, input value_type grad,
         input int gap);
      work_entry_type w;
      w = '{what: ENTRY_ITEM, action: action, value: value, grad: grad, kind: KIND_NONE,
            gap: gap};
      pending_work.push_back(w);
   endtask

   // register writes only once the pipeline has emptied
   task automatic queue_kind(input logic [KIND_W-1:0] kind);
      work_entry_type w;
      w = '{what: ENTRY_DRAIN, action: ACTION_FORWARD, value: '0, grad: '0, kind: kind, gap: 0};
      pending_work.push_back(w);
      w.what = ENTRY_CSR;
      pending_work.push_back(w);
   endtask

   task automatic flag_mismatch(input string what, input value_type want, input value_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) begin
         $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(negedge clock) begin : driver
      logic next_start;
      logic next_csr;
      next_start = start;
      next_csr = csr_valid;
      if (!reset) begin
         if (start && req_taken) begin
            next_start = 1'b0;
         end
         if (csr_valid && csr_taken) begin
            next_csr = 1'b0;
         end
         if (!next_start && !next_csr && pending_work.size() != 0) begin
            case (pending_work[0].what)
               ENTRY_ITEM: begin
                  if (pending_work[0].gap != 0) begin
                     pending_work[0].gap = pending_work[0].gap - 1;
                  end else begin
                     req_action <= pending_work[0].action;
                     req_value <= pending_work[0].value;
                     req_upstream_grad <= pending_work[0].grad;
                     next_start = 1'b1;
                     void'(pending_work.pop_front());
                  end
               end
               ENTRY_CSR: begin
                  csr_activation_kind <= pending_work[0].kind;
                  next_csr = 1'b1;
                  void'(pending_work.pop_front());
               end
               default: begin
                  if (awaited_results.size() != 0) begin
                     settle_left = SETTLE_CYCLES;
                  end else if (settle_left != 0) begin
                     settle_left--;
                  end else begin
                     settle_left = SETTLE_CYCLES;
                     void'(pending_work.pop_front());
                  end
               end
            endcase
         end
      end
      start <= next_start;
      csr_valid <= next_csr;
   end

   always @(posedge clock) begin : monitor
      value_type want;
      req_taken <= !reset && start && !busy;
      csr_taken <= !reset && csr_valid && csr_ready;
      if (reset) begin
         active_kind = KIND_NONE;
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               flag_mismatch("result with no transaction pending", 'x, rsp_result);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_result !== want) begin
                  flag_mismatch("rsp_result", want, rsp_result);
               end
            end
         end
         if (start && !busy) begin
            awaited_results.push_back(predict_activation(active_kind, req_action, req_value,
                                                         req_upstream_grad));
         end
         if (csr_valid && csr_ready) begin
            active_kind = csr_activation_kind;
         end
      end
   end

   initial begin : stimulus
      logic [KIND_W-1:0] directed_kinds [4];
      logic [KIND_W-1:0] phase_kind;
      longint unsigned   y;
      longint unsigned   n;
      longint unsigned   e;
      longint unsigned   e1;
      longint unsigned   num;
      longint unsigned   den;
      longint unsigned   t;
      int                first_kind;
      int                gap_max;
      int                phase_len;

      // tanh curve, Q30 internally, rounded to FRAC bits
      e1 = exp_decay_unit(UNIT_Q30);
      for (int k = 0; k <= CURVE_N; k++) begin
         y = ((64'(k) << (46 - FRAC)) + 64'(CURVE_N / 2)) / 64'(CURVE_N);
         n = y >> 30;
         e = exp_decay_unit(y & (UNIT_Q30 - 64'd1));
         while (n != 0 && e != 0) begin
            e = (e * e1 + (64'd1 << 29)) >> 30;
            n--;
         end
         num = (UNIT_Q30 - e) << 30;
         den = UNIT_Q30 + e;
         t = (num + den / 2) / den;
         tanh_curve[k] = longint'((t + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
      end

      // kind after reset is none
      queue_item(ACTION_FORWARD, -16'sd1, rand_word(), 0);
      queue_item(ACTION_BACKWARD, 16'sd5, VALUE_MIN, 2);

      directed_kinds = '{KIND_SIGMOID, KIND_TANH, KIND_RELU, KIND_LEAKY};
      foreach (directed_kinds[i]) begin
         queue_kind(directed_kinds[i]);
         queue_item(ACTION_FORWARD, VALUE_MAX, rand_word(), $urandom_range(0, 2));
         queue_item(ACTION_FORWARD, VALUE_MIN, rand_word(), $urandom_range(0, 2));
         queue_item(ACTION_FORWARD, 16'sd0, rand_word(), 0);
         queue_item(ACTION_BACKWARD, VALUE_MIN, VALUE_MAX, 0);
         queue_item(ACTION_BACKWARD, 16'sd0, VALUE_MIN, $urandom_range(0, 2));
      end

      queue_kind(KIND_SPARE);
      queue_item(ACTION_FORWARD, 16'sd1234, VALUE_MAX, 0);
      queue_item(ACTION_BACKWARD, -16'sd5, VALUE_MAX, 1);

      first_kind = $urandom_range(0, 7);
      for (int p = 0; p < 12; p++) begin
         if (p < 8) begin
            phase_kind = KIND_W'((first_kind + p) % 8);
         end else begin
            phase_kind = KIND_W'($urandom_range(0, 7));
         end
         case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 18;
         endcase
         queue_kind(phase_kind);
         phase_len = $urandom_range(100, 160);
         repeat (phase_len) begin
            queue_item(($urandom_range(0, 1) == 0) ? ACTION_FORWARD : ACTION_BACKWARD,
                       rand_word(), rand_word(), $urandom_range(0, gap_max));
         end
      end

      while (reset || pending_work.size() != 0 || start || csr_valid ||
             awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
